@@ hw/rtl/odometry_linear_upsampler_defines.svh @@
// Assertion macros shared by the upsampler RTL.
`ifndef ODOMETRY_LINEAR_UPSAMPLER_DEFINES_SVH
`define ODOMETRY_LINEAR_UPSAMPLER_DEFINES_SVH

// Plain property, checked on every rising edge outside reset.
`define OUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define OUP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OUP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/oup_pkg.sv @@
// Types and constants of the odometry upsampler.
package oup_pkg;

  localparam int MAX_FACTOR       = 63;
  localparam int FACTOR_W         = 6;
  localparam int INTERVAL_W       = 24;
  localparam int TIME_W           = 40;
  localparam int POS_W            = 32;
  localparam int DIFF_W           = POS_W + 1;
  localparam int ACC_W            = POS_W + 2;
  localparam int DIV_W            = 40;
  localparam int DIV_BITS_PER_CYC = 8;
  localparam int DIV_CYCLES       = DIV_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = $clog2(DIV_CYCLES + 1);
  localparam int CFG_IDX_W        = 1;

  localparam logic [FACTOR_W-1:0]   FACTOR_RESET   = 6'd4;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd25600;
  localparam logic [TIME_W-1:0]     TIME_MAX       = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_FACTOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 1'd1;

  typedef struct packed {
    logic signed [POS_W-1:0] sample_x;
    logic signed [POS_W-1:0] sample_y;
    logic signed [POS_W-1:0] sample_heading;
    logic                    is_final;
  } oup_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_heading;
    logic [TIME_W-1:0]       out_time;
    logic                    last_of_run;
  } oup_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_FINAL
  } oup_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // input beat taken
    logic step;      // emit one interpolated point
    logic fin_emit;  // emit the final sample itself
  } oup_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_prev;
    logic sample_final;
    logic cur_final;
    logic div_busy;
    logic last_j;
    logic out_free;
  } oup_sts_t;

endpackage

@@ hw/rtl/odometry_linear_upsampler.sv @@
// Top level of the odometry upsampler: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i   (oup_in_t)
//   out      output     out_valid_o / out_ready_i out_data_o  (oup_out_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// First sample of a recording: no beats, or one beat of the sample itself
// if it is also final. Later samples: accept, then the three parallel
// dividers (8 quotient bits a cycle over 40 bits), a hand-over to the point
// loop, then one beat per cycle, while the output is free, for factor
// points (one for a factor of 0), plus one for a final sample.
// Output stalls hold the point loop; a new sample is taken once the last
// beat sits in the output register. Reset is asynchronous, active low.
module odometry_linear_upsampler import oup_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  oup_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output oup_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_data_i
);

  oup_cmd_t cmd;
  oup_sts_t sts;

  oup_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  oup_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

@@ hw/rtl/oup_div.sv @@
// Restoring divider by a small unsigned divisor, several bits per cycle.
`include "odometry_linear_upsampler_defines.svh"

module oup_div import oup_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_W-1:0]    dividend_i,
  input  logic [FACTOR_W-1:0] divisor_i,
  output logic                busy_o,
  output logic [DIV_W-1:0]    quotient_o,
  output logic [FACTOR_W-1:0] remainder_o
);

  logic [DIV_W-1:0]     dq_q, dq_d;
  logic [FACTOR_W-1:0]  rem_q, rem_d;
  logic [FACTOR_W-1:0]  den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  // dq holds the unconsumed dividend bits on top, quotient bits fill in below
  always_comb begin
    logic [FACTOR_W:0] trial;
    dq_d  = dq_q;
    rem_d = rem_q;
    trial = '0;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      trial = {rem_d, dq_d[DIV_W-1]};
      dq_d  = {dq_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial   = trial - {1'b0, den_q};
        dq_d[0] = 1'b1;
      end
      rem_d = trial[FACTOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

  `OUP_ASSERT_NEXT(a_div_start_busy, start_i, busy_q && cnt_q == DIV_CNT_W'(DIV_CYCLES), "divider did not start")
  `OUP_ASSERT_IMP(a_div_idle_cnt, !busy_q, cnt_q == '0, "divider idle with steps left")

endmodule

@@ hw/rtl/oup_ctrl.sv @@
// Sequencing state machine of the odometry upsampler.
`include "odometry_linear_upsampler_defines.svh"

module oup_ctrl import oup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  oup_sts_t sts_i,
  output oup_cmd_t cmd_o
);

  oup_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          if (sts_i.have_prev) begin
            state_d = ST_DIV;
          end else if (sts_i.sample_final) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd_o.step && sts_i.last_j) begin
          state_d = sts_i.cur_final ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (cmd_o.fin_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o.load     = in_valid_i && in_ready_o;
    cmd_o.step     = (state_q == ST_EMIT) && sts_i.out_free;
    cmd_o.fin_emit = (state_q == ST_FINAL) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `OUP_ASSERT_IMP(a_emit_after_div, state_q == ST_EMIT && $past(state_q) == ST_DIV, !$past(sts_i.div_busy), "points began before division ended")
  `OUP_ASSERT_NEXT(a_last_leaves_emit, cmd_o.step && sts_i.last_j, state_q != ST_EMIT, "segment overran its factor")
  `OUP_ASSERT_NEXT(a_final_to_idle, cmd_o.fin_emit, state_q == ST_IDLE, "final beat did not end the item")

endmodule

@@ hw/rtl/oup_dp.sv @@
// Datapath: config registers, sample state, dividers, interpolation and output register.
module oup_dp import oup_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_data_i,
  input  oup_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output oup_out_t              out_data_o,
  input  oup_cmd_t              cmd_i,
  output oup_sts_t              sts_o
);

  logic [FACTOR_W-1:0]   factor_q, f_eff;
  logic [INTERVAL_W-1:0] interval_q;

  oup_in_t           cur_q;
  logic [POS_W-1:0]  prev_x_q, prev_y_q, prev_h_q;
  logic              have_prev_q;
  logic [TIME_W-1:0] seg_q;

  logic [FACTOR_W-1:0]   j_q;
  logic [ACC_W-1:0]      qx_q, qy_q;
  logic [FACTOR_W-1:0]   rx_q, ry_q, rt_q;
  logic [INTERVAL_W-1:0] qt_q;

  oup_out_t out_q;
  logic     out_valid_q;

  logic [DIFF_W-1:0]   diff_x, diff_y;
  logic [DIV_W-1:0]    dvd_x, dvd_y, dvd_t, bias;
  logic [DIV_W-1:0]    quo_x, quo_y, quo_t;
  logic [FACTOR_W-1:0] rd_x, rd_y, rd_t;
  logic                busy_x, busy_y, busy_t, div_start;
  logic [ACC_W-1:0]    qd_x, qd_y;

  logic [FACTOR_W:0]   stp_x, stp_y, stp_t;
  logic [ACC_W-1:0]    qx_d, qy_d;
  logic [INTERVAL_W-1:0] qt_d;
  logic [TIME_W:0]     tsum, ssum;
  logic [TIME_W-1:0]   t_point, seg_adv;
  logic                last_j, out_free;
  oup_out_t            point;

  // {carry, new remainder} of one accumulation step
  function automatic logic [FACTOR_W:0] rem_step(logic [FACTOR_W-1:0] r,
                                                 logic [FACTOR_W-1:0] rd,
                                                 logic [FACTOR_W-1:0] f);
    logic [FACTOR_W:0] s;
    s = {1'b0, r} + {1'b0, rd};
    if (s >= {1'b0, f}) begin
      s = s - {1'b0, f};
      return {1'b1, s[FACTOR_W-1:0]};
    end
    return {1'b0, s[FACTOR_W-1:0]};
  endfunction

  always_comb begin
    if (factor_q == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (factor_q > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor_q;
    end
  end

  // Signed floor division made unsigned: add f * 2^33, strip it from the quotient
  assign diff_x = {in_data_i.sample_x[POS_W-1], in_data_i.sample_x}
                - {prev_x_q[POS_W-1], prev_x_q};
  assign diff_y = {in_data_i.sample_y[POS_W-1], in_data_i.sample_y}
                - {prev_y_q[POS_W-1], prev_y_q};
  assign bias   = DIV_W'({f_eff, {DIFF_W{1'b0}}});
  assign dvd_x  = {{(DIV_W-DIFF_W){diff_x[DIFF_W-1]}}, diff_x} + bias;
  assign dvd_y  = {{(DIV_W-DIFF_W){diff_y[DIFF_W-1]}}, diff_y} + bias;
  assign dvd_t  = DIV_W'(interval_q);
  assign div_start = cmd_i.load && have_prev_q;

  oup_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_x), .divisor_i(f_eff),
    .busy_o(busy_x), .quotient_o(quo_x), .remainder_o(rd_x)
  );
  oup_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_y), .divisor_i(f_eff),
    .busy_o(busy_y), .quotient_o(quo_y), .remainder_o(rd_y)
  );
  oup_div u_div_t (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_t), .divisor_i(f_eff),
    .busy_o(busy_t), .quotient_o(quo_t), .remainder_o(rd_t)
  );

  assign qd_x = {~quo_x[ACC_W-1], quo_x[ACC_W-2:0]};
  assign qd_y = {~quo_y[ACC_W-1], quo_y[ACC_W-2:0]};

  always_comb begin
    stp_x = rem_step(rx_q, rd_x, f_eff);
    stp_y = rem_step(ry_q, rd_y, f_eff);
    stp_t = rem_step(rt_q, rd_t, f_eff);
    qx_d  = qx_q + qd_x + ACC_W'(stp_x[FACTOR_W]);
    qy_d  = qy_q + qd_y + ACC_W'(stp_y[FACTOR_W]);
    qt_d  = qt_q + quo_t[INTERVAL_W-1:0] + INTERVAL_W'(stp_t[FACTOR_W]);

    tsum    = {1'b0, seg_q} + (TIME_W+1)'(qt_q);
    t_point = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
    ssum    = {1'b0, seg_q} + (TIME_W+1)'(interval_q);
    seg_adv = ssum[TIME_W] ? TIME_MAX : ssum[TIME_W-1:0];

    last_j   = (j_q == f_eff - 1'b1);
    out_free = !out_valid_q || out_ready_i;

    point.out_x       = prev_x_q + qx_q[POS_W-1:0];
    point.out_y       = prev_y_q + qy_q[POS_W-1:0];
    point.out_heading = prev_h_q;
    point.out_time    = t_point;
    point.last_of_run = last_j && !cur_q.is_final;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q    <= FACTOR_RESET;
      interval_q  <= INTERVAL_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_h_q    <= '0;
      have_prev_q <= 1'b0;
      seg_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_INTERP_FACTOR:  factor_q   <= cfg_data_i[FACTOR_W-1:0];
          CFG_FRAME_INTERVAL: interval_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        j_q <= '0;
        if (!have_prev_q && !in_data_i.is_final) begin
          prev_x_q    <= in_data_i.sample_x;
          prev_y_q    <= in_data_i.sample_y;
          prev_h_q    <= in_data_i.sample_heading;
          have_prev_q <= 1'b1;
        end
      end

      if (cmd_i.step) begin
        j_q <= j_q + 1'b1;
        if (last_j) begin
          seg_q <= seg_adv;
          if (!cur_q.is_final) begin
            prev_x_q <= cur_q.sample_x;
            prev_y_q <= cur_q.sample_y;
            prev_h_q <= cur_q.sample_heading;
          end
        end
      end

      if (cmd_i.fin_emit) begin
        prev_x_q    <= cur_q.sample_x;
        prev_y_q    <= cur_q.sample_y;
        prev_h_q    <= cur_q.sample_heading;
        have_prev_q <= 1'b0;
        seg_q       <= '0;
      end

      if (cmd_i.step || cmd_i.fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= in_data_i;
      qx_q  <= '0;
      qy_q  <= '0;
      qt_q  <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
      rt_q  <= '0;
    end else if (cmd_i.step) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qt_q <= qt_d;
      rx_q <= stp_x[FACTOR_W-1:0];
      ry_q <= stp_y[FACTOR_W-1:0];
      rt_q <= stp_t[FACTOR_W-1:0];
    end

    if (cmd_i.step) begin
      out_q <= point;
    end else if (cmd_i.fin_emit) begin
      out_q.out_x       <= cur_q.sample_x;
      out_q.out_y       <= cur_q.sample_y;
      out_q.out_heading <= cur_q.sample_heading;
      out_q.out_time    <= seg_q;
      out_q.last_of_run <= 1'b1;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.have_prev    = have_prev_q;
    sts_o.sample_final = in_data_i.is_final;
    sts_o.cur_final    = cur_q.is_final;
    sts_o.div_busy     = busy_x || busy_y || busy_t;
    sts_o.last_j       = last_j;
    sts_o.out_free     = out_free;
  end

endmodule
